// ----- rtl/core/ffba_pkg.sv -----
// Shared constants, status codes and the header store access word for the
// first-fit block allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

  localparam int HEAP_BLOCKS = 4096;
  localparam int BLOCK_BYTES = 64;
  localparam int IDX_W       = 13;
  localparam int ADDR_W      = $clog2(HEAP_BLOCKS);
  localparam int SHIFT_W     = $clog2(BLOCK_BYTES);
  localparam int BASE_W      = 26;
  localparam int COUNT_W     = 13;
  localparam int REQ_W       = 16;
  localparam int NEED_W      = REQ_W + 1;
  localparam int STAT_W      = 4;

  localparam logic [IDX_W-1:0] NO_LINK = {IDX_W{1'b1}};

  localparam logic [STAT_W-1:0] ST_OK        = 4'd0;
  localparam logic [STAT_W-1:0] ST_NULL      = 4'd1;
  localparam logic [STAT_W-1:0] ST_MISALIGN  = 4'd2;
  localparam logic [STAT_W-1:0] ST_RANGE     = 4'd3;
  localparam logic [STAT_W-1:0] ST_DBL_FREE  = 4'd4;
  localparam logic [STAT_W-1:0] ST_OVL_NEXT  = 4'd5;
  localparam logic [STAT_W-1:0] ST_OVL_PREV  = 4'd6;
  localparam logic [STAT_W-1:0] ST_NO_FIT    = 4'd7;
  localparam logic [STAT_W-1:0] ST_ZERO_SIZE = 4'd8;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              size_we;
    logic              link_we;
    logic [IDX_W-1:0]  size_wd;
    logic [IDX_W-1:0]  link_wd;
  } mem_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/ffba_ram.sv -----
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- rtl/core/ffba_ctrl.sv -----
// Sequencer of the allocator: clearing pass, list walk and header updates
// through one shared header store port. Depends on ffba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl import ffba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               mode_i,
  input  logic [REQ_W-1:0]   request_blocks_i,
  input  logic [31:0]        release_address_i,
  input  logic [BASE_W-1:0]  base_i,
  input  logic [COUNT_W-1:0] used_i,
  input  logic               init_i,
  input  logic [IDX_W-1:0]   size_rd_i,
  input  logic [IDX_W-1:0]   link_rd_i,
  output mem_req_t           mem_o,
  output logic               busy_o,
  output logic               done_o,
  output logic [31:0]        granted_address_o,
  output logic [STAT_W-1:0]  status_o
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_A_RD, S_A_EV, S_A_W1, S_A_W2, S_A_W3,
    S_F_RD, S_F_EV, S_F_OR, S_F_OE, S_F_W1, S_F_W2, S_F_NR, S_F_NE, S_F_PM
  } state_e;

  localparam int HDR_W = 32 - SHIFT_W;

  state_e             state_q;
  logic [ADDR_W-1:0]  clr_q;
  logic               pend_q;
  logic [IDX_W-1:0]   head_q, cur_q, prev_q, steps_q, sz_q, lk_q, nxt_q;
  logic [IDX_W-1:0]   off_q, soff_q, psz_q, osz_q, olk_q;
  logic [NEED_W-1:0]  need_q;
  logic               oor_q, mnext_q, mprev_q;
  logic               done_q;
  logic [31:0]        addr_q;
  logic [STAT_W-1:0]  stat_q;

  logic [IDX_W-1:0]   rs, rl;
  logic [HDR_W-1:0]   hdr;
  logic [BASE_W:0]    lim;
  logic [HDR_W-1:0]   offw;
  logic [IDX_W:0]     off_end, prev_end;
  logic [BASE_W:0]    gsum;
  logic [IDX_W:0]     nd_sum;
  logic [IDX_W-1:0]   nd;
  logic [IDX_W-1:0]   widx;

  // out-of-store reads give size zero and no link
  assign rs = oor_q ? '0 : size_rd_i;
  assign rl = oor_q ? NO_LINK : link_rd_i;

  assign hdr      = HDR_W'(release_address_i >> SHIFT_W) - HDR_W'(1);
  assign lim      = (BASE_W+1)'(base_i) + (BASE_W+1)'(used_i) - (BASE_W+1)'(1);
  assign offw     = hdr - HDR_W'(base_i);
  assign off_end  = {1'b0, off_q} + {1'b0, rs};
  assign prev_end = {1'b0, prev_q} + {1'b0, psz_q};
  assign gsum     = (BASE_W+1)'(base_i) + (BASE_W+1)'(cur_q) + (BASE_W+1)'(1);
  assign nd_sum   = {1'b0, cur_q} + {1'b0, need_q[IDX_W-1:0]};
  assign nd       = nd_sum[IDX_W-1:0];

  // header store port
  always_comb begin
    widx            = cur_q;
    mem_o.size_we   = 1'b0;
    mem_o.link_we   = 1'b0;
    mem_o.size_wd   = '0;
    mem_o.link_wd   = NO_LINK;
    unique case (state_q)
      S_CLR: begin
        widx          = IDX_W'(clr_q);
        mem_o.size_we = 1'b1;
        mem_o.link_we = 1'b1;
        mem_o.size_wd = (clr_q == '0) ? used_i : '0;
      end
      S_IDLE: begin
        widx          = '0;
        mem_o.size_we = pend_q;
        mem_o.link_we = pend_q;
        mem_o.size_wd = used_i;
      end
      S_A_W1: begin
        // a remainder header past the index range is never stored
        widx          = nd;
        mem_o.size_we = !nd_sum[IDX_W];
        mem_o.link_we = !nd_sum[IDX_W];
        mem_o.size_wd = sz_q - need_q[IDX_W-1:0];
        mem_o.link_wd = lk_q;
      end
      S_A_W2: begin
        widx          = prev_q;
        mem_o.link_we = (prev_q != NO_LINK);
        mem_o.link_wd = nxt_q;
      end
      S_A_W3: begin
        mem_o.size_we = 1'b1;
        mem_o.link_we = 1'b1;
        mem_o.size_wd = need_q[IDX_W-1:0];
      end
      S_F_OR: widx = off_q;
      S_F_W1: begin
        widx          = off_q;
        mem_o.link_we = 1'b1;
        mem_o.link_wd = cur_q;
      end
      S_F_W2: begin
        widx          = prev_q;
        mem_o.link_we = (prev_q != NO_LINK);
        mem_o.link_wd = off_q;
      end
      S_F_NE: begin
        widx          = off_q;
        mem_o.size_we = 1'b1;
        mem_o.link_we = 1'b1;
        mem_o.size_wd = soff_q + rs;
        mem_o.link_wd = rl;
      end
      S_F_PM: begin
        widx          = prev_q;
        mem_o.size_we = 1'b1;
        mem_o.link_we = 1'b1;
        mem_o.size_wd = psz_q + osz_q;
        mem_o.link_wd = olk_q;
      end
      default: widx = cur_q;
    endcase
    // drop writes beyond the store
    if (widx >= IDX_W'(HEAP_BLOCKS)) begin
      mem_o.size_we = 1'b0;
      mem_o.link_we = 1'b0;
    end
    mem_o.addr = widx[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      head_q  <= '0;
      done_q  <= 1'b0;
      oor_q   <= 1'b0;
      addr_q  <= '0;
      stat_q  <= ST_OK;
    end else begin
      done_q <= 1'b0;
      oor_q  <= (widx >= IDX_W'(HEAP_BLOCKS));
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(HEAP_BLOCKS - 1)) begin
            head_q  <= '0;
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pend_q) begin
            head_q <= '0;
            pend_q <= 1'b0;
          end else if (start_i) begin
            cur_q   <= head_q;
            prev_q  <= NO_LINK;
            steps_q <= '0;
            need_q  <= NEED_W'(request_blocks_i) + NEED_W'(1);
            off_q   <= IDX_W'(offw);
            addr_q  <= '0;
            if (mode_i == MODE_ALLOC) begin
              if (request_blocks_i == '0) begin
                stat_q <= ST_ZERO_SIZE;
                done_q <= 1'b1;
              end else begin
                state_q <= S_A_RD;
              end
            end else if (release_address_i == '0) begin
              stat_q <= ST_NULL;
              done_q <= 1'b1;
            end else if (release_address_i[SHIFT_W-1:0] != '0) begin
              stat_q <= ST_MISALIGN;
              done_q <= 1'b1;
            end else if ((HDR_W+1)'(hdr) < (HDR_W+1)'(base_i) ||
                         (HDR_W+1)'(hdr) >= (HDR_W+1)'(lim)) begin
              stat_q <= ST_RANGE;
              done_q <= 1'b1;
            end else begin
              state_q <= S_F_RD;
            end
          end
        end
        S_A_RD: begin
          if (cur_q == NO_LINK) begin
            stat_q  <= ST_NO_FIT;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_A_EV;
          end
        end
        S_A_EV: begin
          sz_q <= rs;
          lk_q <= rl;
          if (NEED_W'(rs) >= need_q) begin
            nxt_q   <= (NEED_W'(rs) > need_q) ? nd : rl;
            state_q <= (NEED_W'(rs) > need_q) ? S_A_W1 : S_A_W2;
          end else if (steps_q < IDX_W'(HEAP_BLOCKS)) begin
            prev_q  <= cur_q;
            cur_q   <= rl;
            steps_q <= steps_q + IDX_W'(1);
            state_q <= S_A_RD;
          end else begin
            stat_q  <= ST_NO_FIT;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        S_A_W1: state_q <= S_A_W2;
        S_A_W2: begin
          if (prev_q == NO_LINK) begin
            head_q <= nxt_q;
          end
          state_q <= S_A_W3;
        end
        S_A_W3: begin
          addr_q  <= 32'(gsum) << SHIFT_W;
          stat_q  <= ST_OK;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        S_F_RD: begin
          if (cur_q != NO_LINK && cur_q < off_q && steps_q < IDX_W'(HEAP_BLOCKS)) begin
            state_q <= S_F_EV;
          end else begin
            state_q <= S_F_OR;
          end
        end
        S_F_EV: begin
          prev_q  <= cur_q;
          psz_q   <= rs;
          cur_q   <= rl;
          steps_q <= steps_q + IDX_W'(1);
          state_q <= S_F_RD;
        end
        S_F_OR: state_q <= S_F_OE;
        S_F_OE: begin
          soff_q  <= rs;
          osz_q   <= rs;
          olk_q   <= cur_q;
          mnext_q <= (cur_q != NO_LINK) && (off_end == {1'b0, cur_q});
          mprev_q <= (prev_q != NO_LINK) && (prev_end == {1'b0, off_q});
          if (cur_q != NO_LINK && cur_q == off_q) begin
            stat_q  <= ST_DBL_FREE;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (cur_q != NO_LINK && {1'b0, cur_q} < off_end) begin
            stat_q  <= ST_OVL_NEXT;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else if (prev_q != NO_LINK && prev_end > {1'b0, off_q}) begin
            stat_q  <= ST_OVL_PREV;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_F_W1;
          end
        end
        S_F_W1: state_q <= S_F_W2;
        S_F_W2: begin
          if (prev_q == NO_LINK) begin
            head_q <= off_q;
          end
          state_q <= mnext_q ? S_F_NR : (mprev_q ? S_F_PM : S_IDLE);
          if (!mnext_q && !mprev_q) begin
            stat_q <= ST_OK;
            done_q <= 1'b1;
          end
        end
        S_F_NR: state_q <= S_F_NE;
        S_F_NE: begin
          osz_q   <= soff_q + rs;
          olk_q   <= rl;
          state_q <= mprev_q ? S_F_PM : S_IDLE;
          if (!mprev_q) begin
            stat_q <= ST_OK;
            done_q <= 1'b1;
          end
        end
        S_F_PM: begin
          stat_q  <= ST_OK;
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      if (init_i) begin
        pend_q <= 1'b1;
      end
    end
  end

  assign busy_o            = (state_q != S_IDLE) || pend_q;
  assign done_o            = done_q;
  assign granted_address_o = addr_q;
  assign status_o          = stat_q;

endmodule
`default_nettype wire

// ----- rtl/core/first_fit_block_allocator_core.sv -----
// Top level of the first-fit block allocator: configuration registers,
// sequencer and header stores. Depends on ffba_pkg, ffba_ctrl, ffba_ram.
//
//  channel  | handshake              | word
//  ---------+------------------------+---------------------------------------
//  request  | start_i, busy_o        | mode_i, request_blocks_i, release_address_i
//  result   | done_o (strobe)        | granted_address_o, status_o
//  config   | cfg_valid_i, cfg_ready_o | cfg_index_i, cfg_data_i
//
// Each free-list step is a read and an evaluate state on the single header
// store port, so an allocate or a free lasts longer the more extents it walks.
// Argument errors are answered from the idle state without a list walk.
// After reset a clearing pass over all HEAP_BLOCKS (4096) headers holds busy_o high.
// A configuration write is held pending and rewrites header zero once idle.
// The result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator_core import ffba_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic [REQ_W-1:0]   request_blocks_i,
  input  logic [31:0]        release_address_i,
  output logic               done_o,
  output logic [31:0]        granted_address_o,
  output logic [STAT_W-1:0]  status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [BASE_W-1:0]  cfg_data_i
);

  logic [BASE_W-1:0]  base_q;
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] used;
  logic               cfg_wr;
  mem_req_t           mem;
  logic [IDX_W-1:0]   size_rd, link_rd;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= COUNT_W'(HEAP_BLOCKS);
    end else if (cfg_wr) begin
      if (cfg_index_i == CFG_BASE) begin
        base_q <= cfg_data_i;
      end else begin
        count_q <= cfg_data_i[COUNT_W-1:0];
      end
    end
  end

  // saturate the block count into the store
  always_comb begin
    used = count_q;
    if (count_q < COUNT_W'(2)) begin
      used = COUNT_W'(2);
    end else if (count_q > COUNT_W'(HEAP_BLOCKS)) begin
      used = COUNT_W'(HEAP_BLOCKS);
    end
  end

  ffba_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .mode_i            (mode_i),
    .request_blocks_i  (request_blocks_i),
    .release_address_i (release_address_i),
    .base_i            (base_q),
    .used_i            (used),
    .init_i            (cfg_wr),
    .size_rd_i         (size_rd),
    .link_rd_i         (link_rd),
    .mem_o             (mem),
    .busy_o            (busy_o),
    .done_o            (done_o),
    .granted_address_o (granted_address_o),
    .status_o          (status_o)
  );

  ffba_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_BLOCKS)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (mem.size_we),
    .waddr_i (mem.addr),
    .wdata_i (mem.size_wd),
    .raddr_i (mem.addr),
    .rdata_o (size_rd)
  );

  ffba_ram #(.WIDTH(IDX_W), .DEPTH(HEAP_BLOCKS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem.link_we),
    .waddr_i (mem.addr),
    .wdata_i (mem.link_wd),
    .raddr_i (mem.addr),
    .rdata_o (link_rd)
  );

endmodule
`default_nettype wire

// ----- rtl/core/ffba_chk.sv -----
// Port-level checks for the allocator core, bound to the top level.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ffba_chk import ffba_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_o,
  input logic              done_o,
  input logic [31:0]       granted_address_o,
  input logic [STAT_W-1:0] status_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted word neither busy nor answered");

  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> granted_address_o == '0)
    else $error("failed request returned an address");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o <= ST_ZERO_SIZE)
    else $error("status code out of range");

  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> granted_address_o[SHIFT_W-1:0] == '0)
    else $error("granted address not block aligned");

endmodule

bind first_fit_block_allocator_core ffba_chk u_ffba_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .done_o            (done_o),
  .granted_address_o (granted_address_o),
  .status_o          (status_o)
);
`default_nettype wire
